>>> hdl/pfi_pkg.sv
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared constants, codes and types of the per-type packet fault injector.
// ----------------------------------------------------------------------------
package pfi_pkg;

    localparam int TYPE_COUNT  = 256;
    localparam int PAYLOAD_MAX = 32;

    localparam int TYPE_AW  = (TYPE_COUNT > 2) ? $clog2(TYPE_COUNT) : 1;
    localparam int FZ_DEPTH = TYPE_COUNT * PAYLOAD_MAX;
    localparam int FZ_AW    = $clog2(FZ_DEPTH);
    localparam int POS_W    = 6;

    localparam logic [POS_W-1:0] POS_SAT    = '1;
    localparam logic [7:0]       BIAS_RESET = 8'h10;

    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_STUCK  = 2'd1,
        KIND_OFFSET = 2'd2,
        KIND_DROP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_BYTE   = 2'd0,
        RES_DROP   = 2'd1,
        RES_REPORT = 2'd2
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] type_id;
        logic [1:0] fault_kind;
        logic [7:0] data_byte;
        logic       last_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] kind_out;
        logic       injected;
        logic       too_long;
    } res_item_t;

    // one entry of the per-type table
    typedef struct packed {
        logic [1:0]       kind;
        logic             fvalid;
        logic [POS_W-1:0] flen;
    } tm_entry_t;

    localparam int TM_W = $bits(tm_entry_t);

    typedef struct packed {
        logic               re;
        logic [TYPE_AW-1:0] raddr;
        logic               we;
        logic [TYPE_AW-1:0] waddr;
        tm_entry_t          wdata;
    } tm_req_t;

    typedef struct packed {
        logic             re;
        logic [FZ_AW-1:0] raddr;
        logic             we;
        logic [FZ_AW-1:0] waddr;
        logic [7:0]       wdata;
    } fz_req_t;

endpackage

>>> hdl/pfi_cmd_if.sv
// ----------------------------------------------------------------------------
// pfi_cmd_if
// Command channel: valid/ready handshake with the command item fields.
// ----------------------------------------------------------------------------
interface pfi_cmd_if;

    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] type_id;
    logic [1:0] fault_kind;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (
        output valid,
        output action,
        output type_id,
        output fault_kind,
        output data_byte,
        output last_byte,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  type_id,
        input  fault_kind,
        input  data_byte,
        input  last_byte,
        output ready
    );

endinterface

>>> hdl/pfi_res_if.sv
// ----------------------------------------------------------------------------
// pfi_res_if
// Result channel: valid/ready handshake with the result item fields.
// ----------------------------------------------------------------------------
interface pfi_res_if;

    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] kind_out;
    logic       injected;
    logic       too_long;

    modport source (
        output valid,
        output result_kind,
        output out_byte,
        output out_last,
        output kind_out,
        output injected,
        output too_long,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_kind,
        input  out_byte,
        input  out_last,
        input  kind_out,
        input  injected,
        input  too_long,
        output ready
    );

endinterface

>>> hdl/pfi_ram.sv
// ----------------------------------------------------------------------------
// pfi_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/pfi_ctrl.sv
// ----------------------------------------------------------------------------
// pfi_ctrl
// Sequencer: reads the type entry, applies the fault, updates the table and
// the frozen byte store, and replays frozen packets through the output register.
// ----------------------------------------------------------------------------
module pfi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfi_pkg::cmd_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output pfi_pkg::res_item_t out_item,
    input  logic [7:0]         bias,
    output pfi_pkg::tm_req_t   tm_req,
    input  pfi_pkg::tm_entry_t tm_rdata,
    output pfi_pkg::fz_req_t   fz_req,
    input  logic [7:0]         fz_rdata
);

    import pfi_pkg::*;

    localparam logic [POS_W-1:0] PMAX = POS_W'(PAYLOAD_MAX);

    state_t            state_reg, state_next;
    cmd_item_t         item_reg;
    logic [7:0]        t_reg;
    logic              ok_reg;
    logic              ent_vq_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        cur_type_reg;
    logic [TYPE_COUNT-1:0] ent_valid_reg;
    logic [FZ_AW-1:0]  base_reg, base_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic              tl_reg, tl_next;
    logic [POS_W-1:0]  idx_reg;
    res_item_t         out_item_reg, out_load_item;
    logic              out_valid_reg;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              lk_emit;
    logic              lk_replay;
    logic              lk_advance;
    logic [7:0]        look_type;
    tm_entry_t         entry;
    logic [1:0]        cur_kind;
    logic [POS_W-1:0]  new_len;
    logic [POS_W-1:0]  stored_len;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // type of the addressed entry: a packet keeps the type of its first byte
    always_comb
    begin
        if (in_item.action == ACT_BYTE && pos_reg != '0)
        begin
            look_type = cur_type_reg;
        end
        else
        begin
            look_type = in_item.type_id;
        end
    end

    assign entry    = ent_vq_reg ? tm_rdata : '0;
    assign cur_kind = ok_reg ? entry.kind : KIND_NONE;
    assign new_len  = (pos_reg >= PMAX) ? PMAX : pos_reg + POS_W'(1);
    assign stored_len = (entry.flen > PMAX) ? PMAX : entry.flen;
    assign base_next  = FZ_AW'(t_reg[TYPE_AW-1:0]) * FZ_AW'(PAYLOAD_MAX);

    assign pos_next = item_reg.last_byte ? '0
                    : ((pos_reg == POS_SAT) ? pos_reg : pos_reg + POS_W'(1));

    // lookup stage decision
    always_comb
    begin
        lk_emit       = 1'b0;
        lk_replay     = 1'b0;
        out_load_item = '0;
        len_next      = stored_len;
        tl_next       = 1'b0;
        out_load_item.kind_out = cur_kind;
        case (item_reg.action)
            ACT_SET:
            begin
                lk_emit = 1'b1;
                out_load_item.result_kind = RES_REPORT;
                out_load_item.out_last    = 1'b1;
                out_load_item.kind_out    = ok_reg ? item_reg.fault_kind : KIND_NONE;
            end
            ACT_QUERY:
            begin
                lk_emit = 1'b1;
                out_load_item.result_kind = RES_REPORT;
                out_load_item.out_last    = 1'b1;
            end
            ACT_BYTE:
            begin
                case (cur_kind)
                    KIND_NONE:
                    begin
                        lk_emit = 1'b1;
                        out_load_item.result_kind = RES_BYTE;
                        out_load_item.out_byte    = item_reg.data_byte;
                        out_load_item.out_last    = item_reg.last_byte;
                    end
                    KIND_OFFSET:
                    begin
                        lk_emit = 1'b1;
                        out_load_item.result_kind = RES_BYTE;
                        out_load_item.out_byte    = (pos_reg == POS_W'(1))
                                                  ? item_reg.data_byte + bias
                                                  : item_reg.data_byte;
                        out_load_item.out_last    = item_reg.last_byte;
                        out_load_item.injected    = 1'b1;
                    end
                    KIND_DROP:
                    begin
                        lk_emit = item_reg.last_byte;
                        out_load_item.result_kind = RES_DROP;
                        out_load_item.out_last    = 1'b1;
                    end
                    default:
                    begin
                        // stuck: replay on every last byte, capture closes here too
                        lk_replay = item_reg.last_byte;
                        if (!entry.fvalid)
                        begin
                            len_next = new_len;
                            tl_next  = item_reg.last_byte && (pos_reg >= PMAX);
                        end
                    end
                endcase
            end
            default:
            begin
                lk_emit = 1'b0;
            end
        endcase
    end

    assign lk_advance = !lk_emit || out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (lk_advance)
                begin
                    state_next = lk_replay ? ST_RD : ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (idx_reg == len_reg - POS_W'(1)) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and memory requests
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_load = 1'b0;

        tm_req       = '0;
        tm_req.re    = accept;
        tm_req.raddr = look_type[TYPE_AW-1:0];
        tm_req.waddr = t_reg[TYPE_AW-1:0];

        fz_req       = '0;
        fz_req.raddr = base_reg + FZ_AW'(idx_reg);
        fz_req.waddr = base_next + FZ_AW'(pos_reg);
        fz_req.wdata = item_reg.data_byte;

        case (state_reg)
            ST_LOOKUP:
            begin
                if (lk_advance)
                begin
                    out_load = lk_emit;
                    if (item_reg.action == ACT_SET)
                    begin
                        tm_req.we           = ok_reg;
                        tm_req.wdata.kind   = item_reg.fault_kind;
                        tm_req.wdata.fvalid = 1'b0;
                        tm_req.wdata.flen   = '0;
                    end
                    else if (item_reg.action == ACT_BYTE && cur_kind == KIND_STUCK
                             && !entry.fvalid)
                    begin
                        fz_req.we = (pos_reg < PMAX);
                        tm_req.we           = item_reg.last_byte;
                        tm_req.wdata.kind   = KIND_STUCK;
                        tm_req.wdata.fvalid = 1'b1;
                        tm_req.wdata.flen   = new_len;
                    end
                end
            end
            ST_RD:
            begin
                fz_req.re = 1'b1;
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            cur_type_reg  <= '0;
            ent_valid_reg <= '0;
            ent_vq_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                ent_vq_reg <= ent_valid_reg[look_type[TYPE_AW-1:0]];
                if (in_item.action == ACT_BYTE && pos_reg == '0)
                begin
                    cur_type_reg <= in_item.type_id;
                end
            end
            if (state_reg == ST_LOOKUP && lk_advance && item_reg.action == ACT_BYTE)
            begin
                pos_reg <= pos_next;
            end
            if (tm_req.we)
            begin
                ent_valid_reg[tm_req.waddr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_LOOKUP)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_EMIT && out_free)
            begin
                idx_reg <= idx_reg + POS_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
            t_reg    <= look_type;
            ok_reg   <= ({1'b0, look_type} < 9'(TYPE_COUNT));
        end
        if (state_reg == ST_LOOKUP && lk_advance && lk_replay)
        begin
            base_reg <= base_next;
            len_reg  <= len_next;
            tl_reg   <= tl_next;
        end
        if (out_load)
        begin
            if (state_reg == ST_EMIT)
            begin
                out_item_reg.result_kind <= RES_BYTE;
                out_item_reg.out_byte    <= fz_rdata;
                out_item_reg.out_last    <= (idx_reg == len_reg - POS_W'(1));
                out_item_reg.kind_out    <= KIND_STUCK;
                out_item_reg.injected    <= 1'b1;
                out_item_reg.too_long    <= tl_reg;
            end
            else
            begin
                out_item_reg <= out_load_item;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOKUP)
        else $error("accepted item did not enter lookup");

    a_rd_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |=> state_reg == ST_EMIT)
        else $error("frozen read not followed by emit");

    a_replay_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> idx_reg < len_reg)
        else $error("replay index beyond frozen length");

    a_no_write_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_EMIT) |-> !tm_req.we && !fz_req.we)
        else $error("table write during replay");

    a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten while held");

endmodule

>>> hdl/per_type_packet_fault_injector.sv
// ----------------------------------------------------------------------------
// per_type_packet_fault_injector
// Per-type fault injection (none, stuck, offset, drop) on a payload stream.
// ----------------------------------------------------------------------------
// order: an accepted item enters the lookup state, which reads the registered type
// entry and loads the result into the output register, held while res.ready is low;
// a new item is accepted only in the idle state, once the previous one is through;
// on the last byte of a stuck packet, each frozen byte is read from the store, then emitted
// reset: control cleared, all types read as kind none with no capture, bias 16;
// the frozen byte store is not cleared, so no clearing pass is needed
module per_type_packet_fault_injector (
    input  logic        clk,
    input  logic        rst_n,
    pfi_cmd_if.sink     cmd,
    pfi_res_if.source   res,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    import pfi_pkg::*;

    logic [7:0]  bias_reg;
    cmd_item_t   in_item;
    res_item_t   out_item;
    tm_req_t     tm_req;
    tm_entry_t   tm_rdata;
    logic [TM_W-1:0] tm_rdata_raw;
    fz_req_t     fz_req;
    logic [7:0]  fz_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= BIAS_RESET;
        end
        else if (cfg_we)
        begin
            bias_reg <= cfg_wdata;
        end
    end

    assign in_item.action     = cmd.action;
    assign in_item.type_id    = cmd.type_id;
    assign in_item.fault_kind = cmd.fault_kind;
    assign in_item.data_byte  = cmd.data_byte;
    assign in_item.last_byte  = cmd.last_byte;

    assign res.result_kind = out_item.result_kind;
    assign res.out_byte    = out_item.out_byte;
    assign res.out_last    = out_item.out_last;
    assign res.kind_out    = out_item.kind_out;
    assign res.injected    = out_item.injected;
    assign res.too_long    = out_item.too_long;

    assign tm_rdata = tm_rdata_raw;

    pfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_item   (in_item),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_item  (out_item),
        .bias      (bias_reg),
        .tm_req    (tm_req),
        .tm_rdata  (tm_rdata),
        .fz_req    (fz_req),
        .fz_rdata  (fz_rdata)
    );

    pfi_ram #(
        .WIDTH (TM_W),
        .DEPTH (TYPE_COUNT)
    ) u_type_ram (
        .clk   (clk),
        .we    (tm_req.we),
        .waddr (tm_req.waddr),
        .wdata (tm_req.wdata),
        .re    (tm_req.re),
        .raddr (tm_req.raddr),
        .rdata (tm_rdata_raw)
    );

    pfi_ram #(
        .WIDTH (8),
        .DEPTH (FZ_DEPTH)
    ) u_frozen_ram (
        .clk   (clk),
        .we    (fz_req.we),
        .waddr (fz_req.waddr),
        .wdata (fz_req.wdata),
        .re    (fz_req.re),
        .raddr (fz_req.raddr),
        .rdata (fz_rdata)
    );

endmodule
